[hdl/fckv_pkg.sv]
// ----------------------------------------------------------------------------
// Fixed-capacity key/value table package
// Shared widths, request kinds and controller states for the table.
// ----------------------------------------------------------------------------
package fckv_pkg;

  // Default sizing of the table.
  localparam int DefCapacity  = 256;
  localparam int DefKeyBits   = 32;
  localparam int DefValueBits = 32;

  // Fixed widths of the channel fields.
  localparam int KindW      = 3;
  localparam int KeyPortW   = 32;
  localparam int ValPortW   = 32;
  localparam int PosW       = 8;
  localparam int CountPortW = 9;

  // Request kinds. Codes six and seven are unused and change nothing.
  typedef enum logic [KindW-1:0] {
    KIND_INSERT = 3'd0,
    KIND_UPDATE = 3'd1,
    KIND_UPSERT = 3'd2,
    KIND_ERASE  = 3'd3,
    KIND_LOOKUP = 3'd4,
    KIND_READ   = 3'd5
  } req_kind_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_READ
  } fckv_state_e;

endpackage

[hdl/fckv_if.sv]
// ----------------------------------------------------------------------------
// Fixed-capacity key/value table channels
// Valid/ready interfaces for the request and the response channel.
// ----------------------------------------------------------------------------

// Request channel: one table operation per transfer.
interface fckv_req_if import fckv_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KindW-1:0]    req_type;
  logic [KeyPortW-1:0] key_in;
  logic [ValPortW-1:0] value_in;
  logic [PosW-1:0]     position;

  modport source (output valid, output req_type, output key_in, output value_in,
                  output position, input ready);
  modport sink   (input valid, input req_type, input key_in, input value_in,
                  input position, output ready);
endinterface

// Response channel: one result per request.
interface fckv_rsp_if import fckv_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  ok;
  logic [KeyPortW-1:0]   key_out;
  logic [ValPortW-1:0]   value_out;
  logic [CountPortW-1:0] entry_count;

  modport source (output valid, output ok, output key_out, output value_out,
                  output entry_count, input ready);
  modport sink   (input valid, input ok, input key_out, input value_out,
                  input entry_count, output ready);
endinterface

[hdl/fixed_capacity_key_value_table_top.sv]
// ----------------------------------------------------------------------------
// Fixed-capacity key/value table
// Bounded table of unique key/value pairs in insertion order, held in one RAM.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Transfer               Fields
//   req_i     in         valid & ready          req_type key_in value_in position
//   rsp_o     out        valid & ready          ok key_out value_out entry_count
//
// One request is handled at a time. A read by position reads the entry at that
// position if it lies below the count; a key search reads the entries in order
// from index 0 until a hit or the end. An erase hit then moves each later entry
// down one place. Search and shift step through the entries one per cycle over
// the single RAM read port. The entry RAM is not cleared at reset; only the
// state, the pair count and the response valid flag are. A new request is taken
// only when the controller is idle and the response register is empty or is
// being read in the same cycle.
// ----------------------------------------------------------------------------
module fixed_capacity_key_value_table_top import fckv_pkg::*; #(
  parameter int CAPACITY   = DefCapacity,
  parameter int KEY_BITS   = DefKeyBits,
  parameter int VALUE_BITS = DefValueBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fckv_req_if.sink   req_i,
  fckv_rsp_if.source rsp_o
);

  localparam int IdxW = $clog2(CAPACITY);
  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int KeyW = (KEY_BITS < KeyPortW) ? KEY_BITS : KeyPortW;
  localparam int ValW = (VALUE_BITS < ValPortW) ? VALUE_BITS : ValPortW;
  localparam int EntW = KeyW + ValW;
  localparam int CmpW = (CntW > PosW) ? CntW : PosW;
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  fckv_state_e state_q, state_d;
  req_kind_e   kind_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] val_q;
  logic [CntW-1:0] scan_q, scan_d;
  logic [CntW-1:0] count_q, count_d;

  logic                  rsp_valid_q;
  logic                  rsp_ok_q;
  logic [KeyPortW-1:0]   rsp_key_q;
  logic [ValPortW-1:0]   rsp_val_q;
  logic [CountPortW-1:0] rsp_cnt_q;

  logic                rsp_load;
  logic                rsp_ok_d;
  logic [KeyPortW-1:0] rsp_key_d;
  logic [ValPortW-1:0] rsp_val_d;

  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [EntW-1:0] mem_wdata;
  logic [IdxW-1:0] mem_raddr;
  logic [EntW-1:0] mem_rdata;

  logic            req_fire;
  req_kind_e       in_kind;
  logic [KeyW-1:0] in_key;
  logic [ValW-1:0] in_val;
  logic [CmpW-1:0] pos_ext;
  logic [CmpW-1:0] cnt_ext;
  logic            pos_hit;
  logic            by_key;
  logic [KeyW-1:0] rd_key;
  logic [ValW-1:0] rd_val;
  logic            match;
  logic            room;
  logic            adds;
  logic [IdxW-1:0] scan_idx;
  logic [IdxW-1:0] prev_idx;

  // Request decode and handshake.
  assign req_i.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign req_fire    = req_i.valid && req_i.ready;
  assign in_kind     = req_kind_e'(req_i.req_type);
  assign in_key      = req_i.key_in[KeyW-1:0];
  assign in_val      = req_i.value_in[ValW-1:0];
  assign pos_ext     = CmpW'(req_i.position);
  assign cnt_ext     = CmpW'(count_q);
  assign pos_hit     = pos_ext < cnt_ext;
  assign by_key      = in_kind inside {KIND_INSERT, KIND_UPDATE, KIND_UPSERT,
                                       KIND_ERASE, KIND_LOOKUP};

  // Search datapath. During a search the RAM output holds entry scan_q - 1.
  assign rd_key   = mem_rdata[EntW-1:ValW];
  assign rd_val   = mem_rdata[ValW-1:0];
  assign match    = rd_key == key_q;
  assign room     = count_q < CapCnt;
  assign adds     = (kind_q == KIND_INSERT) || (kind_q == KIND_UPSERT);
  assign scan_idx = scan_q[IdxW-1:0];
  assign prev_idx = scan_idx - IdxW'(1);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          if (by_key && (count_q != '0)) begin
            state_d = ST_SEARCH;
          end else if ((in_kind == KIND_READ) && pos_hit) begin
            state_d = ST_READ;
          end
        end
      end
      ST_SEARCH: begin
        if (match) begin
          state_d = (kind_q == KIND_ERASE) ? ST_SHIFT : ST_IDLE;
        end else if (scan_q == count_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        if (!(scan_q < count_q)) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // RAM accesses, count and result.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = prev_idx;
    mem_wdata = {key_q, val_q};
    mem_raddr = scan_idx;
    scan_d    = scan_q;
    count_d   = count_q;
    rsp_load  = 1'b0;
    rsp_ok_d  = 1'b0;
    rsp_key_d = '0;
    rsp_val_d = '0;
    case (state_q)
      ST_IDLE: begin
        mem_raddr = (in_kind == KIND_READ) ? pos_ext[IdxW-1:0] : '0;
        scan_d    = CntW'(1);
        if (req_fire) begin
          if (by_key) begin
            // An empty table misses at once; an add goes to entry zero.
            if (count_q == '0) begin
              rsp_load = 1'b1;
              if ((in_kind == KIND_INSERT) || (in_kind == KIND_UPSERT)) begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = {in_key, in_val};
                count_d   = CntW'(1);
                rsp_ok_d  = 1'b1;
              end
            end
          end else if (!((in_kind == KIND_READ) && pos_hit)) begin
            rsp_load = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        if (match) begin
          case (kind_q)
            KIND_UPDATE, KIND_UPSERT: begin
              mem_we   = 1'b1;
              rsp_load = 1'b1;
              rsp_ok_d = 1'b1;
            end
            KIND_LOOKUP: begin
              rsp_load  = 1'b1;
              rsp_ok_d  = 1'b1;
              rsp_val_d = ValPortW'(rd_val);
            end
            KIND_ERASE: begin
              // The next entry is already being read; the shift starts here.
            end
            default: begin
              rsp_load = 1'b1;
            end
          endcase
        end else if (scan_q == count_q) begin
          // Key absent: append when the request adds and there is room.
          rsp_load = 1'b1;
          if (adds && room) begin
            mem_we    = 1'b1;
            mem_waddr = count_q[IdxW-1:0];
            count_d   = count_q + CntW'(1);
            rsp_ok_d  = 1'b1;
          end
        end else begin
          scan_d = scan_q + CntW'(1);
        end
      end
      ST_SHIFT: begin
        // Move entry scan_q down one place while reading the one after it.
        mem_raddr = scan_idx + IdxW'(1);
        if (scan_q < count_q) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          scan_d    = scan_q + CntW'(1);
        end else begin
          count_d  = count_q - CntW'(1);
          rsp_load = 1'b1;
          rsp_ok_d = 1'b1;
        end
      end
      ST_READ: begin
        rsp_load  = 1'b1;
        rsp_ok_d  = 1'b1;
        rsp_key_d = KeyPortW'(rd_key);
        rsp_val_d = ValPortW'(rd_val);
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Request capture, scan pointer and response payload.
  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    if (req_fire) begin
      kind_q <= in_kind;
      key_q  <= in_key;
      val_q  <= in_val;
    end
    if (rsp_load) begin
      rsp_ok_q  <= rsp_ok_d;
      rsp_key_q <= rsp_key_d;
      rsp_val_q <= rsp_val_d;
      rsp_cnt_q <= CountPortW'(count_d);
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.ok          = rsp_ok_q;
  assign rsp_o.key_out     = rsp_key_q;
  assign rsp_o.value_out   = rsp_val_q;
  assign rsp_o.entry_count = rsp_cnt_q;

  // Entry memory: key in the upper bits, value in the lower bits.
  fckv_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (EntW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // The pair count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("pair count above capacity");

  // A search keeps its pointer between one and the count.
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> ((scan_q != '0) && (scan_q <= count_q)))
    else $error("search pointer out of range");

  // The count changes only as a request completes.
  a_count_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(rsp_load))
    else $error("pair count changed outside request completion");

  // Every RAM write lands inside the occupied region.
  a_write_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (CntW'(mem_waddr) < count_d))
    else $error("write outside occupied entries");

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_load |-> (!rsp_valid_q || rsp_o.ready))
    else $error("response overwritten before transfer");

endmodule

[hdl/fckv_ram.sv]
// ----------------------------------------------------------------------------
// Fixed-capacity key/value table entry memory
// Simple dual-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module fckv_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
